[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is skipped while reset is held.
`define DLMP_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Clocked assertion that also holds during reset.
`define DLMP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

[rtl/dlmp_pkg.sv]
// Package with the beat types, parse phases and record codes of the mesh parser.
`timescale 1ns / 1ps
package dlmp_pkg;

    // Record kinds.
    localparam logic [3:0] K_GATE       = 4'd0;
    localparam logic [3:0] K_POINT      = 4'd1;
    localparam logic [3:0] K_RUNREF     = 4'd2;
    localparam logic [3:0] K_NORMAL     = 4'd3;
    localparam logic [3:0] K_SHAREDVERT = 4'd4;
    localparam logic [3:0] K_VERT       = 4'd5;
    localparam logic [3:0] K_EDGE       = 4'd6;
    localparam logic [3:0] K_FACESTART  = 4'd7;
    localparam logic [3:0] K_FACEEDGE   = 4'd8;
    localparam logic [3:0] K_FACECOLOR  = 4'd9;
    localparam logic [3:0] K_LINE       = 4'd10;
    localparam logic [3:0] K_END        = 4'd11;
    localparam logic [3:0] K_ERROR      = 4'd12;
    localparam logic [3:0] K_UNSUP      = 4'd13;

    // Opcode and count codes.
    localparam logic [5:0] FORM_POINT   = 6'h3f;
    localparam logic [5:0] FORM_RUN     = 6'h3e;
    localparam logic [7:0] CNT_REORDER  = 8'hff;
    localparam logic [1:0] CMD_FACE     = 2'd1;

    typedef enum logic [4:0] {
        PH_MODE, PH_HDR, PH_HSKIP, PH_OPC, PH_POINT, PH_RUNHDR, PH_RUNREF,
        PH_NORMAL, PH_VHDR, PH_SVERT, PH_XVERT, PH_EHDR, PH_EDGE, PH_CHDR,
        PH_COPC, PH_FCNT, PH_FEDGE, PH_FCOLOR, PH_LINE, PH_DRAIN
    } t_phase;

    typedef enum logic [1:0] {
        FIN_NONE, FIN_END, FIN_UNSUP
    } t_fin;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    typedef struct packed {
        logic [3:0]         kind;
        logic [7:0]         item_index;
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
        logic signed [15:0] value_c;
        logic signed [15:0] value_d;
        logic [31:0]        vis_mask;
        logic [15:0]        bytes_used;
        logic               sort_bit;
        logic               final_record;
    } t_out;

    // Records produced by one input beat, first in order first.
    typedef struct packed {
        logic [1:0] count;
        t_out       rec0;
        t_out       rec1;
    } t_push;

endpackage

[rtl/dlmp_front.sv]
// Front end: byte-level parse state machine that turns each beat into up to two records.
`timescale 1ns / 1ps
module dlmp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  dlmp_pkg::t_in  i_beat,
    output dlmp_pkg::t_push o_push
);

    dlmp_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_fbc, n_fbc;
    logic [7:0]  r_done, n_done;
    logic [7:0]  r_total, n_total;
    logic [7:0]  r_cmds, n_cmds;
    logic        r_wide, n_wide;
    logic [4:0]  r_ntot, n_ntot;
    logic [63:0] r_asm, n_asm;
    logic [31:0] r_mask, n_mask;
    logic [7:0]  r_copc, n_copc;
    logic [15:0] r_body, n_body;
    logic        r_sort, n_sort;

    // Records made by the current beat: one from the parse step, one closing.
    logic           p_v;
    logic           f_v;
    dlmp_pkg::t_out p_r;
    dlmp_pkg::t_out f_r;

    function automatic dlmp_pkg::t_out mk_rec(
        input logic [3:0] kind, input logic [7:0] idx,
        input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
        input logic [15:0] d, input logic [31:0] mask, input logic [15:0] used,
        input logic srt, input logic fin);
        dlmp_pkg::t_out r;
        r.kind = kind;
        r.item_index = idx;
        r.value_a = a;
        r.value_b = b;
        r.value_c = c;
        r.value_d = d;
        r.vis_mask = mask;
        r.bytes_used = used;
        r.sort_bit = srt;
        r.final_record = fin;
        return r;
    endfunction

    // Next state and records for one accepted beat.
    always_comb begin
        logic [7:0]  b;
        logic        lst;
        logic [2:0]  mb;
        logic [3:0]  c_fbc;
        logic [3:0]  ofs;
        logic [31:0] c_mask;
        logic [63:0] c_asm;
        logic [63:0] w;
        logic        take_op;
        dlmp_pkg::t_fin fin;
        logic [7:0]  dn1;
        logic [7:0]  cm1;

        b = i_beat.data_byte;
        lst = i_beat.last_byte;
        n_phase = r_phase; n_fbc = r_fbc; n_done = r_done; n_total = r_total;
        n_cmds = r_cmds; n_wide = r_wide; n_ntot = r_ntot; n_asm = r_asm;
        n_mask = r_mask; n_copc = r_copc; n_body = r_body; n_sort = r_sort;
        p_v = 1'b0; f_v = 1'b0; take_op = 1'b0; fin = dlmp_pkg::FIN_NONE;
        p_r = '0; f_r = '0;

        // Field collection: mask bytes first, then the data bytes.
        mb = r_wide ? 3'd4 : 3'd2;
        c_fbc = r_fbc + 4'd1;
        ofs = r_fbc - {1'b0, mb};
        c_mask = r_mask;
        c_asm = r_asm;
        if (r_fbc < {1'b0, mb}) begin
            c_mask = r_mask | ({24'd0, b} << {r_fbc[1:0], 3'b000});
        end else begin
            c_asm = r_asm | ({56'd0, b} << {ofs[2:0], 3'b000});
        end
        w = r_asm | ({56'd0, b} << {r_fbc[2:0], 3'b000});
        dn1 = r_done + 8'd1;
        cm1 = r_cmds - 8'd1;

        if (r_phase == dlmp_pkg::PH_DRAIN) begin
            if (lst) begin
                n_phase = dlmp_pkg::PH_MODE;
            end
        end else if (r_phase == dlmp_pkg::PH_MODE) begin
            // Render mode byte: clear everything.
            n_phase = dlmp_pkg::PH_HDR;
            n_fbc = '0; n_done = '0; n_total = '0; n_cmds = '0; n_wide = 1'b0;
            n_ntot = '0; n_asm = '0; n_mask = '0; n_copc = '0; n_body = '0;
            n_sort = 1'b0;
            if (lst) begin
                f_v = 1'b1;
                f_r = mk_rec(dlmp_pkg::K_ERROR, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
                n_phase = dlmp_pkg::PH_MODE;
            end
        end else begin
            // Body byte count, header bytes excluded.
            if (r_phase != dlmp_pkg::PH_HSKIP &&
                !(r_phase == dlmp_pkg::PH_HDR && b[7]) && r_body != 16'hffff) begin
                n_body = r_body + 16'd1;
            end

            unique case (r_phase)
                dlmp_pkg::PH_HDR: begin
                    if (b[7]) begin
                        n_mask = {28'd0, 1'b1, b[2:0]};
                        n_fbc = '0;
                        n_phase = dlmp_pkg::PH_HSKIP;
                    end else begin
                        if (r_mask[3]) begin
                            p_v = 1'b1;
                            p_r = mk_rec(dlmp_pkg::K_GATE, {5'd0, r_mask[2:0]}, '0, '0,
                                         '0, '0, '0, '0, 1'b0, 1'b0);
                        end
                        n_mask = '0;
                        if (b[6:5] == 2'b11) begin
                            n_phase = dlmp_pkg::PH_OPC;
                        end else begin
                            take_op = 1'b1;
                        end
                    end
                end
                dlmp_pkg::PH_HSKIP: begin
                    n_fbc = c_fbc;
                    if (c_fbc >= 4'd2) begin
                        n_fbc = '0;
                        n_phase = dlmp_pkg::PH_HDR;
                    end
                end
                dlmp_pkg::PH_OPC: begin
                    take_op = 1'b1;
                end
                dlmp_pkg::PH_POINT: begin
                    p_v = 1'b1;
                    p_r = mk_rec(dlmp_pkg::K_POINT, b, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
                    fin = dlmp_pkg::FIN_END;
                end
                dlmp_pkg::PH_RUNHDR: begin
                    n_fbc = c_fbc;
                    if (c_fbc >= 4'd2) begin
                        n_fbc = '0;
                        n_total = b;
                        n_done = '0;
                        if (b != 8'd0) begin
                            n_phase = dlmp_pkg::PH_RUNREF;
                        end else begin
                            fin = dlmp_pkg::FIN_END;
                        end
                    end
                end
                dlmp_pkg::PH_RUNREF: begin
                    p_v = 1'b1;
                    p_r = mk_rec(dlmp_pkg::K_RUNREF, b, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
                    n_done = dn1;
                    if (dn1 == r_total) begin
                        fin = dlmp_pkg::FIN_END;
                    end
                end
                dlmp_pkg::PH_NORMAL: begin
                    n_asm = w;
                    n_fbc = c_fbc;
                    if (c_fbc >= 4'd8) begin
                        p_v = 1'b1;
                        p_r = mk_rec(dlmp_pkg::K_NORMAL, r_done, w[15:0], w[31:16],
                                     w[47:32], w[63:48], '0, '0, 1'b0, 1'b0);
                        n_done = dn1; n_fbc = '0; n_mask = '0; n_asm = '0;
                        if (dn1 == r_total) begin
                            n_phase = dlmp_pkg::PH_VHDR;
                        end
                    end
                end
                dlmp_pkg::PH_VHDR: begin
                    n_done = '0;
                    n_total = {1'b0, b[6:0]};
                    n_fbc = '0; n_mask = '0; n_asm = '0;
                    if (b[6:0] == 7'd0) begin
                        n_phase = dlmp_pkg::PH_EHDR;
                    end else begin
                        n_phase = b[7] ? dlmp_pkg::PH_SVERT : dlmp_pkg::PH_XVERT;
                    end
                end
                dlmp_pkg::PH_SVERT, dlmp_pkg::PH_XVERT, dlmp_pkg::PH_EDGE,
                dlmp_pkg::PH_LINE: begin
                    n_fbc = c_fbc; n_mask = c_mask; n_asm = c_asm;
                    if (r_phase == dlmp_pkg::PH_SVERT &&
                        c_fbc >= {1'b0, mb} + 4'd1) begin
                        p_v = 1'b1;
                        p_r = mk_rec(dlmp_pkg::K_SHAREDVERT, c_asm[7:0], '0, '0, '0, '0,
                                     c_mask, '0, 1'b0, 1'b0);
                    end
                    if (r_phase == dlmp_pkg::PH_XVERT &&
                        c_fbc >= {1'b0, mb} + 4'd6) begin
                        p_v = 1'b1;
                        p_r = mk_rec(dlmp_pkg::K_VERT, r_done, c_asm[15:0], c_asm[31:16],
                                     c_asm[47:32], '0, c_mask, '0, 1'b0, 1'b0);
                    end
                    if ((r_phase == dlmp_pkg::PH_EDGE || r_phase == dlmp_pkg::PH_LINE) &&
                        c_fbc >= {1'b0, mb} + 4'd2) begin
                        p_v = 1'b1;
                        p_r = mk_rec((r_phase == dlmp_pkg::PH_EDGE) ? dlmp_pkg::K_EDGE
                                                                     : dlmp_pkg::K_LINE,
                                     r_done, {8'd0, c_asm[7:0]}, {8'd0, c_asm[15:8]},
                                     '0, '0, c_mask, '0, 1'b0, 1'b0);
                    end
                    if (p_v) begin
                        n_done = dn1; n_fbc = '0; n_mask = '0; n_asm = '0;
                        if (r_phase == dlmp_pkg::PH_LINE) begin
                            // Command finished.
                            n_cmds = cm1;
                            if (cm1 == 8'd0) begin
                                fin = dlmp_pkg::FIN_END;
                            end else begin
                                n_phase = dlmp_pkg::PH_COPC;
                            end
                        end else if (dn1 == r_total) begin
                            n_phase = (r_phase == dlmp_pkg::PH_EDGE) ? dlmp_pkg::PH_CHDR
                                                                     : dlmp_pkg::PH_EHDR;
                        end
                    end
                end
                dlmp_pkg::PH_EHDR: begin
                    n_total = b; n_done = '0;
                    n_fbc = '0; n_mask = '0; n_asm = '0;
                    n_phase = (b != 8'd0) ? dlmp_pkg::PH_EDGE : dlmp_pkg::PH_CHDR;
                end
                dlmp_pkg::PH_CHDR: begin
                    if (b == 8'd0) begin
                        fin = dlmp_pkg::FIN_END;
                    end else if (b == dlmp_pkg::CNT_REORDER) begin
                        fin = dlmp_pkg::FIN_UNSUP;
                    end else begin
                        n_cmds = b; n_done = '0;
                        n_phase = dlmp_pkg::PH_COPC;
                    end
                end
                dlmp_pkg::PH_COPC: begin
                    n_copc = b;
                    n_fbc = '0; n_mask = '0; n_asm = '0;
                    n_phase = (b[1:0] == dlmp_pkg::CMD_FACE) ? dlmp_pkg::PH_FCNT
                                                             : dlmp_pkg::PH_LINE;
                end
                dlmp_pkg::PH_FCNT: begin
                    p_v = 1'b1;
                    p_r = mk_rec(dlmp_pkg::K_FACESTART, b, {11'd0, r_copc[7], r_copc[6:3]},
                                 '0, '0, '0, '0, '0, 1'b0, 1'b0);
                    n_total = b;
                    n_phase = (b != 8'd0) ? dlmp_pkg::PH_FEDGE : dlmp_pkg::PH_FCOLOR;
                end
                dlmp_pkg::PH_FEDGE: begin
                    p_v = 1'b1;
                    p_r = mk_rec(dlmp_pkg::K_FACEEDGE, b, '0, '0, '0, '0, '0, '0, 1'b0, 1'b0);
                    n_total = r_total - 8'd1;
                    if (r_total == 8'd1) begin
                        n_phase = dlmp_pkg::PH_FCOLOR;
                    end
                end
                dlmp_pkg::PH_FCOLOR: begin
                    p_v = 1'b1;
                    p_r = mk_rec(dlmp_pkg::K_FACECOLOR, b, '0, '0, '0, '0, '0, '0,
                                 1'b0, 1'b0);
                    n_done = dn1;
                    n_cmds = cm1;
                    if (cm1 == 8'd0) begin
                        fin = dlmp_pkg::FIN_END;
                    end else begin
                        n_phase = dlmp_pkg::PH_COPC;
                    end
                end
                default: begin
                    n_phase = dlmp_pkg::PH_MODE;
                end
            endcase

            // Opcode byte: point, edge run or model.
            if (take_op) begin
                n_sort = b[6];
                n_fbc = '0; n_mask = '0; n_asm = '0;
                if (b[5:0] == dlmp_pkg::FORM_POINT) begin
                    n_phase = dlmp_pkg::PH_POINT;
                end else if (b[5:0] == dlmp_pkg::FORM_RUN) begin
                    n_phase = dlmp_pkg::PH_RUNHDR;
                end else begin
                    n_ntot = b[4:0];
                    n_wide = (b[4:0] > 5'd16);
                    n_done = '0;
                    n_total = {3'd0, b[4:0]};
                    n_phase = (b[4:0] != 5'd0) ? dlmp_pkg::PH_NORMAL : dlmp_pkg::PH_VHDR;
                end
            end

            // Closing record.
            if (fin == dlmp_pkg::FIN_END) begin
                f_v = 1'b1;
                f_r = mk_rec(dlmp_pkg::K_END, '0, '0, '0, '0, '0, '0, n_body, n_sort, 1'b1);
                n_phase = lst ? dlmp_pkg::PH_MODE : dlmp_pkg::PH_DRAIN;
            end else if (fin == dlmp_pkg::FIN_UNSUP) begin
                f_v = 1'b1;
                f_r = mk_rec(dlmp_pkg::K_UNSUP, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
                n_phase = lst ? dlmp_pkg::PH_MODE : dlmp_pkg::PH_DRAIN;
            end else if (lst) begin
                f_v = 1'b1;
                f_r = mk_rec(dlmp_pkg::K_ERROR, '0, '0, '0, '0, '0, '0, '0, 1'b0, 1'b1);
                n_phase = dlmp_pkg::PH_MODE;
            end
        end
    end

    // Pack the records in order; nothing is pushed without an accepted beat.
    always_comb begin
        o_push.count = i_take ? ({1'b0, p_v} + {1'b0, f_v}) : 2'd0;
        o_push.rec0 = p_v ? p_r : f_r;
        o_push.rec1 = f_r;
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dlmp_pkg::PH_MODE;
            r_fbc <= '0; r_done <= '0; r_total <= '0; r_cmds <= '0;
            r_wide <= 1'b0; r_ntot <= '0; r_asm <= '0; r_mask <= '0;
            r_copc <= '0; r_body <= '0; r_sort <= 1'b0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_fbc <= n_fbc; r_done <= n_done; r_total <= n_total; r_cmds <= n_cmds;
            r_wide <= n_wide; r_ntot <= n_ntot; r_asm <= n_asm; r_mask <= n_mask;
            r_copc <= n_copc; r_body <= n_body; r_sort <= n_sort;
        end
    end

endmodule

[rtl/dlmp_queue.sv]
// Back end: four-entry record queue that takes up to two records a beat and emits one.
`timescale 1ns / 1ps
module dlmp_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dlmp_pkg::t_push i_push,
    output logic            o_room,
    output logic            o_valid,
    input  logic            i_ready,
    output dlmp_pkg::t_out  o_data
);

    localparam int unsigned Depth = 4;

    dlmp_pkg::t_out r_q [Depth];
    dlmp_pkg::t_out n_q [Depth];
    logic [2:0] r_cnt, n_cnt;

    // Shift on pop, then append new records behind the survivors.
    always_comb begin
        logic       pop;
        logic [2:0] base;
        pop = (r_cnt != 3'd0) && i_ready;
        base = r_cnt - {2'd0, pop};
        for (int i = 0; i < Depth; i++) begin
            if (pop && i < Depth - 1) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (i_push.count != 2'd0 && 3'(i) == base) begin
                n_q[i] = i_push.rec0;
            end
            if (i_push.count == 2'd2 && 3'(i) == base + 3'd1) begin
                n_q[i] = i_push.rec1;
            end
        end
        n_cnt = base + {1'b0, i_push.count};
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < Depth; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign o_room  = (r_cnt <= 3'd2);
    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_q[0];

endmodule

[rtl/display_list_mesh_parser_core.sv]
// Top level of the display-list mesh parser: parse front end and record queue.
//
//  channel | direction | payload          | handshake
//  input   | in        | i_data (t_in)    | i_valid / o_ready
//  output  | out       | o_data (t_out)   | o_valid / i_ready
//
// While o_ready is high one byte beat is taken per cycle; its records enter the queue
// in the same cycle. A beat makes at most two records, so o_ready needs two free slots.
// Records leave one per cycle from the queue head register while i_ready is high.
// Reset (synchronous, active low) empties the queue and expects a render mode byte.
// A stalled output only stops input once the four-entry queue has under two free slots.
`timescale 1ns / 1ps
module display_list_mesh_parser_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dlmp_pkg::t_in  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output dlmp_pkg::t_out o_data
);

    logic            w_room;
    dlmp_pkg::t_push w_push;

    assign o_ready = w_room;

    dlmp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (i_valid && w_room),
        .i_beat  (i_data),
        .o_push  (w_push)
    );

    dlmp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule

[rtl/dlmp_checker.sv]
// Port-level checker for the mesh parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dlmp_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input dlmp_pkg::t_out o_data
);

    logic w_final_kind;
    logic w_is_end;
    logic w_end_clear;

    // Kind classes used by the checks below.
    assign w_final_kind = (o_data.kind == dlmp_pkg::K_END) ||
                          (o_data.kind == dlmp_pkg::K_ERROR) ||
                          (o_data.kind == dlmp_pkg::K_UNSUP);
    assign w_is_end     = (o_data.kind == dlmp_pkg::K_END);
    assign w_end_clear  = (o_data.bytes_used == 16'd0) && !o_data.sort_bit;

    // A waiting record stays offered.
    `DLMP_ASSERT(a_hold_valid, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid)
    // The closing flag marks exactly the end, error and unsupported kinds.
    `DLMP_ASSERT(a_final_kind, i_clk, i_rst_n, o_valid |-> o_data.final_record == w_final_kind)
    // Only end records carry a byte count or sort flag.
    `DLMP_ASSERT(a_end_fields, i_clk, i_rst_n, o_valid && !w_is_end |-> w_end_clear)
    // Reset leaves no record offered and the input open.
    `DLMP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_valid && o_ready)

endmodule

bind display_list_mesh_parser_core dlmp_checker u_dlmp_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);
